[design/pccl_pkg.sv]
// shared types, constants and display decode for the pulse count code lock
package pccl_pkg;

  // pulse count saturation and the width that holds it
  localparam int unsigned COUNT_MAX = 15;
  localparam int unsigned COUNT_W   = $clog2(COUNT_MAX + 1);

  // field widths
  localparam int unsigned CODE_W  = 4;
  localparam int unsigned TICK_W  = 8;
  localparam int unsigned SEG_W   = 7;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned DATA_W  = 8;

  // register indexes on the configuration channel
  localparam logic [IDX_W-1:0] REG_CODE_FIRST    = 2'd0;
  localparam logic [IDX_W-1:0] REG_CODE_SECOND   = 2'd1;
  localparam logic [IDX_W-1:0] REG_ENTRY_TIMEOUT = 2'd2;
  localparam logic [IDX_W-1:0] REG_ACTION_TICKS  = 2'd3;

  // register reset values
  localparam logic [CODE_W-1:0] CODE_FIRST_RST    = 4'd2;
  localparam logic [CODE_W-1:0] CODE_SECOND_RST   = 4'd3;
  localparam logic [TICK_W-1:0] ENTRY_TIMEOUT_RST = 8'd50;
  localparam logic [TICK_W-1:0] ACTION_TICKS_RST  = 8'd50;

  localparam logic [TICK_W-1:0] TICK_SAT = '1;

  // one input request
  typedef struct packed {
    logic sensor_one;
    logic sensor_two;
    logic clear_request;
  } item_t;

  // one result
  typedef struct packed {
    logic [SEG_W-1:0] segments;
    logic             motor_on;
    logic             buzzer_on;
    logic             led_on;
  } result_t;

  // configuration seen by the lock logic
  typedef struct packed {
    logic [CODE_W-1:0] code_first;
    logic [CODE_W-1:0] code_second;
    logic [TICK_W-1:0] entry_timeout_ticks;
    logic [TICK_W-1:0] action_ticks;
  } cfg_t;

  // seven segment pattern, bit0 segment a; counts above nine show as zero
  function automatic logic [SEG_W-1:0] seg_pattern(input logic [COUNT_W-1:0] c);
    logic [SEG_W-1:0] p;
    case (c)
      COUNT_W'(1): p = 7'h06;
      COUNT_W'(2): p = 7'h5B;
      COUNT_W'(3): p = 7'h4F;
      COUNT_W'(4): p = 7'h66;
      COUNT_W'(5): p = 7'h6D;
      COUNT_W'(6): p = 7'h7D;
      COUNT_W'(7): p = 7'h07;
      COUNT_W'(8): p = 7'h7F;
      COUNT_W'(9): p = 7'h6F;
      default:     p = 7'h3F;
    endcase
    return p;
  endfunction

endpackage

[design/pccl_cfg.sv]
// configuration register file of the code lock
module pccl_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [pccl_pkg::IDX_W-1:0] cfg_index,
  input  logic [pccl_pkg::DATA_W-1:0] cfg_data,
  output pccl_pkg::cfg_t             cfg
);
  import pccl_pkg::*;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.code_first          <= CODE_FIRST_RST;
      cfg.code_second         <= CODE_SECOND_RST;
      cfg.entry_timeout_ticks <= ENTRY_TIMEOUT_RST;
      cfg.action_ticks        <= ACTION_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CODE_FIRST:    cfg.code_first          <= cfg_data[CODE_W-1:0];
        REG_CODE_SECOND:   cfg.code_second         <= cfg_data[CODE_W-1:0];
        REG_ENTRY_TIMEOUT: cfg.entry_timeout_ticks <= cfg_data[TICK_W-1:0];
        REG_ACTION_TICKS:  cfg.action_ticks        <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[design/pccl_core.sv]
// lock state: pulse counters, idle timer, action timer and result decode
module pccl_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  pccl_pkg::item_t   item,
  input  pccl_pkg::cfg_t    cfg,
  output pccl_pkg::result_t res
);
  import pccl_pkg::*;

  logic [COUNT_W-1:0] count_one, count_one_next;
  logic [COUNT_W-1:0] count_two, count_two_next;
  logic               shown_is_two, shown_is_two_next;
  logic               prev_one, prev_two;
  logic [TICK_W-1:0]  idle_ticks, idle_ticks_next;
  logic [TICK_W-1:0]  action_left, action_left_next;
  logic               action_is_open, action_is_open_next;
  logic [TICK_W-1:0]  limit;
  logic [TICK_W-1:0]  idle_inc;
  logic               rise_one, rise_two;
  logic               active;

  assign rise_one = item.sensor_one && !prev_one;
  assign rise_two = item.sensor_two && !prev_two;
  assign limit    = (cfg.entry_timeout_ticks == '0) ? TICK_W'(1) : cfg.entry_timeout_ticks;
  assign idle_inc = (idle_ticks != TICK_SAT) ? idle_ticks + TICK_W'(1) : idle_ticks;

  // next state for one tick
  always_comb begin
    count_one_next      = count_one;
    count_two_next      = count_two;
    shown_is_two_next   = shown_is_two;
    idle_ticks_next     = idle_ticks;
    action_left_next    = action_left;
    action_is_open_next = action_is_open;
    if (item.clear_request) begin
      count_one_next      = '0;
      count_two_next      = '0;
      shown_is_two_next   = 1'b0;
      idle_ticks_next     = '0;
      action_left_next    = '0;
      action_is_open_next = 1'b0;
    end else if (action_left != '0) begin
      action_left_next = action_left - TICK_W'(1);
      if (action_left == TICK_W'(1)) begin
        count_one_next  = '0;
        count_two_next  = '0;
        idle_ticks_next = '0;
      end
    end else begin
      if (rise_one) begin
        if (count_one != COUNT_W'(COUNT_MAX)) count_one_next = count_one + COUNT_W'(1);
        shown_is_two_next = 1'b0;
      end
      if (rise_two) begin
        if (count_two != COUNT_W'(COUNT_MAX)) count_two_next = count_two + COUNT_W'(1);
        shown_is_two_next = 1'b1;
      end
      if (item.sensor_one || item.sensor_two) begin
        idle_ticks_next = '0;
      end else if (count_one != '0 || count_two != '0) begin
        idle_ticks_next = idle_inc;
        // quiet long enough: check the entered code
        if (idle_inc >= limit) begin
          action_is_open_next = (count_one == COUNT_W'(cfg.code_first)) &&
                                (count_two == COUNT_W'(cfg.code_second));
          action_left_next    = (cfg.action_ticks == '0) ? TICK_W'(1) : cfg.action_ticks;
          idle_ticks_next     = '0;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count_one      <= '0;
      count_two      <= '0;
      shown_is_two   <= 1'b0;
      prev_one       <= 1'b0;
      prev_two       <= 1'b0;
      idle_ticks     <= '0;
      action_left    <= '0;
      action_is_open <= 1'b0;
    end else if (step) begin
      count_one      <= count_one_next;
      count_two      <= count_two_next;
      shown_is_two   <= shown_is_two_next;
      prev_one       <= item.sensor_one;
      prev_two       <= item.sensor_two;
      idle_ticks     <= idle_ticks_next;
      action_left    <= action_left_next;
      action_is_open <= action_is_open_next;
    end
  end

  // result of this tick, from the updated state
  assign active        = action_left_next != '0;
  assign res.segments  = seg_pattern(shown_is_two_next ? count_two_next : count_one_next);
  assign res.motor_on  = active && action_is_open_next;
  assign res.buzzer_on = active && !action_is_open_next;
  assign res.led_on    = active;

  // a clear leaves no action running and no counts
  a_clear_stops: assert property (@(posedge clk) disable iff (rst)
    step && item.clear_request |=> action_left == '0 && count_one == '0 && count_two == '0)
    else $error("clear did not stop the action");

  // counts never pass saturation
  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    count_one <= COUNT_W'(COUNT_MAX) && count_two <= COUNT_W'(COUNT_MAX))
    else $error("pulse count beyond saturation");

  // a running action freezes the counts
  a_action_freeze: assert property (@(posedge clk) disable iff (rst)
    step && action_left > TICK_W'(1) && !item.clear_request |=>
      $stable(count_one) && $stable(count_two))
    else $error("count changed during an action");

  // idle timer only runs with pulses entered
  a_idle_needs_count: assert property (@(posedge clk) disable iff (rst)
    idle_ticks != '0 |-> count_one != '0 || count_two != '0)
    else $error("idle timer running with no pulses");

endmodule

[design/pulse_count_code_lock.sv]
// Touchless pulse count code lock, stepped once per timer tick.
// Channels: item requests (two sensor levels and a clear) come in on
// item/item_valid/item_stall; one result request (segments, motor, buzzer,
// LED) per item leaves on result/result_valid/result_stall. A request moves
// at a clock edge where valid is high and stall is low.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 code_first,
// 1 code_second, 2 entry_timeout_ticks, 3 action_ticks) and cfg_data.
// cfg_ready is always high; write only while no item is in flight.
// Path: an accepted item passes through the input register, the lock logic
// and the result register before its result is valid.
// Throughput: one item per cycle while result_stall is low; the lock state
// updates in a single pass as an item leaves the input register.
// Stall: while result_stall holds a waiting result, the input register
// keeps one more item, then item_stall rises until the result is taken.
// Reset (rst, synchronous): registers return to code 2/3 and 50/50 ticks,
// counts, timers and drives clear and both pipeline stages empty.
module pulse_count_code_lock (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  pccl_pkg::item_t             item,
  output logic                        result_valid,
  input  logic                        result_stall,
  output pccl_pkg::result_t           result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pccl_pkg::IDX_W-1:0]  cfg_index,
  input  logic [pccl_pkg::DATA_W-1:0] cfg_data
);
  import pccl_pkg::*;

  cfg_t    cfg;
  item_t   held_item;
  logic    held_valid;
  logic    advance;
  result_t core_res;

  // configuration registers
  pccl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // held item moves on when the result register is free or being drained
  assign advance    = held_valid && (!result_valid || !result_stall);
  assign item_stall = held_valid && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      held_item <= item;
    end
  end

  // lock logic
  pccl_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (held_item),
    .cfg  (cfg),
    .res  (core_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= core_res;
    end
  end

  // motor and buzzer are never driven together
  a_drive_excl: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.motor_on && result.buzzer_on))
    else $error("motor and buzzer both on");

  // led follows either action
  a_led_match: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.led_on == (result.motor_on || result.buzzer_on))
    else $error("led does not match drives");

  // a waiting result blocks the held item
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |-> !advance)
    else $error("result overwritten while stalled");

endmodule

[tb/tb_pulse_count_code_lock.sv]
// self-checking testbench for the pulse count code lock: directed ticks, then random entries
`timescale 1ns / 100ps

module tb_pulse_count_code_lock;
  import pccl_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_CYCLES  = 60;

  // display patterns for digits 0..9, bit0 segment a
  localparam logic [SEG_W-1:0] DIGIT_SEGS [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  // directed ticks as {sensor_one, sensor_two, clear_request}, run at reset settings
  localparam int N_DIRECTED = 17;
  localparam logic [2:0] DIRECTED_TAPS [N_DIRECTED] = '{
    3'b000, // idle with no pulses, no code check
    3'b001, // clear from rest
    3'b110, // both sensors rise together, second count shown
    3'b110, // both held, no edge
    3'b000,
    3'b100, // first sensor alone
    3'b010,
    3'b000,
    3'b010,
    3'b111, // clear with both sensors high
    3'b110, // still high after clear, no edge
    3'b000,
    3'b100,
    3'b011, // clear with second sensor high
    3'b010, // held through clear
    3'b101, // clear with first sensor high
    3'b000
  };

  logic clk;
  logic rst = 1'b1;

  // block ports
  logic                item_valid   = 1'b0;
  logic                item_stall;
  item_t               item         = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  result_t             result;
  logic                cfg_valid    = 1'b0;
  logic                cfg_ready;
  logic [IDX_W-1:0]    cfg_index    = REG_CODE_FIRST;
  logic [DATA_W-1:0]   cfg_data     = '0;

  wire item_fire = item_valid && !item_stall;

  // lock state mirror and its register copy
  cfg_t               lock_cfg = '{CODE_FIRST_RST, CODE_SECOND_RST,
                                   ENTRY_TIMEOUT_RST, ACTION_TICKS_RST};
  logic [COUNT_W-1:0] pulses_one  = '0;
  logic [COUNT_W-1:0] pulses_two  = '0;
  logic               show_second = 1'b0;
  logic               last_one    = 1'b0;
  logic               last_two    = 1'b0;
  logic [TICK_W-1:0]  quiet_ticks = '0;
  logic [TICK_W-1:0]  action_left = '0;
  logic               action_open = 1'b0;

  item_t   pending_taps[$];
  result_t predicted_outputs[$];

  // run control and bookkeeping
  int  gap_left       = 0;
  int  stall_left     = 0;
  int  hold_left      = 0;
  bit  hold_req       = 1'b0;
  bit  hold_done      = 1'b0;
  bit  sender_quiet   = 1'b0;
  bit  receiver_quiet = 1'b0;
  int  phase_taps     = 0;
  int  taps_sent      = 0;
  int  results_seen   = 0;
  int  opens          = 0;
  int  refusals       = 0;
  int  clears         = 0;
  int  failures       = 0;
  int  cycle_count    = 0;

  pulse_count_code_lock DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one tick of the lock; returns the panel outputs of that tick
  function automatic result_t lock_step(input item_t tap);
    logic [TICK_W-1:0]  limit;
    logic [COUNT_W-1:0] shown;
    result_t            panel;
    if (tap.clear_request) begin
      pulses_one  = '0;
      pulses_two  = '0;
      show_second = 1'b0;
      quiet_ticks = '0;
      action_left = '0;
      action_open = 1'b0;
      clears++;
    end else if (action_left != 0) begin
      // sensors ignored while the motor or buzzer runs
      action_left = action_left - TICK_W'(1);
      if (action_left == 0) begin
        pulses_one  = '0;
        pulses_two  = '0;
        quiet_ticks = '0;
      end
    end else begin
      if (tap.sensor_one && !last_one) begin
        if (pulses_one < COUNT_MAX) pulses_one = pulses_one + COUNT_W'(1);
        show_second = 1'b0;
      end
      if (tap.sensor_two && !last_two) begin
        if (pulses_two < COUNT_MAX) pulses_two = pulses_two + COUNT_W'(1);
        show_second = 1'b1;
      end
      if (tap.sensor_one || tap.sensor_two) begin
        quiet_ticks = '0;
      end else if (pulses_one != 0 || pulses_two != 0) begin
        // entry is over once the hands stay away long enough
        limit = (lock_cfg.entry_timeout_ticks == 0) ? TICK_W'(1) : lock_cfg.entry_timeout_ticks;
        if (quiet_ticks != TICK_SAT) quiet_ticks = quiet_ticks + TICK_W'(1);
        if (quiet_ticks >= limit) begin
          action_open = (pulses_one == lock_cfg.code_first) &&
                        (pulses_two == lock_cfg.code_second);
          action_left = (lock_cfg.action_ticks == 0) ? TICK_W'(1) : lock_cfg.action_ticks;
          quiet_ticks = '0;
          if (action_open) opens++;
          else refusals++;
        end
      end
    end
    last_one = tap.sensor_one;
    last_two = tap.sensor_two;

    shown = show_second ? pulses_two : pulses_one;
    panel.segments  = (shown <= 9) ? DIGIT_SEGS[shown] : DIGIT_SEGS[0];
    panel.motor_on  = (action_left != 0) && action_open;
    panel.buzzer_on = (action_left != 0) && !action_open;
    panel.led_on    = (action_left != 0);
    return panel;
  endfunction

  // idle length: mostly none, some short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int eff_ticks(input logic [TICK_W-1:0] v);
    return (v == 0) ? 1 : int'(v);
  endfunction

  // pulse count for a random entry, mostly small, sometimes past saturation
  function automatic int pulse_target();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, COUNT_MAX + 2);
    return $urandom_range(0, 4);
  endfunction

  task automatic push_tap(input bit s1, input bit s2, input bit clr);
    item_t t;
    t.sensor_one    = s1;
    t.sensor_two    = s2;
    t.clear_request = clr;
    pending_taps.push_back(t);
    phase_taps++;
  endtask

  // one user attempt: entry, wrong entry, noise or an aborted entry
  task automatic queue_entry(input int kind);
    int n1, n2, low, wait_len, clr_at, i;
    bit s1, s2;
    if (kind < 7) begin
      if ($urandom_range(0, 1)) begin
        n1 = int'(lock_cfg.code_first);
        n2 = int'(lock_cfg.code_second);
      end else begin
        n1 = pulse_target();
        n2 = pulse_target();
      end
      low = (eff_ticks(lock_cfg.entry_timeout_ticks) > 2) ? 2 : 1;
      // pulses in random order, now and then both sensors together
      while (n1 + n2 > 0) begin
        if (n1 > 0 && n2 > 0 && $urandom_range(0, 3) == 0) begin
          s1 = 1'b1; s2 = 1'b1; n1--; n2--;
        end else if (n1 > 0 && (n2 == 0 || $urandom_range(0, 1))) begin
          s1 = 1'b1; s2 = 1'b0; n1--;
        end else begin
          s1 = 1'b0; s2 = 1'b1; n2--;
        end
        repeat ($urandom_range(1, 2)) push_tap(s1, s2, 1'b0);
        repeat ($urandom_range(1, low)) push_tap(1'b0, 1'b0, 1'b0);
      end
      repeat (eff_ticks(lock_cfg.entry_timeout_ticks)) push_tap(1'b0, 1'b0, 1'b0);
      // action period: hands may wave or stay, and sometimes a clear cuts it short
      wait_len = eff_ticks(lock_cfg.action_ticks) + int'($urandom_range(0, 2));
      clr_at   = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, wait_len - 1)) : -1;
      s1 = 1'($urandom_range(0, 1));
      for (i = 0; i < wait_len; i++) begin
        if ($urandom_range(0, 3) == 0) s1 = ~s1;
        if ($urandom_range(0, 1)) push_tap(s1, 1'($urandom_range(0, 1)), i == clr_at);
        else push_tap(1'b0, 1'b0, i == clr_at);
      end
    end else if (kind < 9) begin
      repeat ($urandom_range(1, 8))
        push_tap(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 $urandom_range(0, 7) == 0);
    end else begin
      // aborted entry: a few pulses, maybe a long hold, then clear
      repeat ($urandom_range(1, 5)) begin
        push_tap(1'($urandom_range(0, 1)), 1'b1, 1'b0);
        push_tap(1'b0, 1'b0, 1'b0);
      end
      if ($urandom_range(0, 1)) repeat ($urandom_range(5, 20)) push_tap(1'b1, 1'b0, 1'b0);
      push_tap(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
    end
  endtask

  task automatic run_phase(input int budget);
    phase_taps = 0;
    while (phase_taps < budget) queue_entry(int'($urandom_range(0, 9)));
  endtask

  // wait until every queued request has left and every result has come back
  task automatic drain();
    do @(negedge clk);
    while (pending_taps.size() != 0 || item_valid || predicted_outputs.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_CODE_FIRST:    lock_cfg.code_first          = data[CODE_W-1:0];
      REG_CODE_SECOND:   lock_cfg.code_second         = data[CODE_W-1:0];
      REG_ENTRY_TIMEOUT: lock_cfg.entry_timeout_ticks = data[TICK_W-1:0];
      REG_ACTION_TICKS:  lock_cfg.action_ticks        = data[TICK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_lock(input logic [DATA_W-1:0] first, input logic [DATA_W-1:0] second,
                          input logic [DATA_W-1:0] timeout, input logic [DATA_W-1:0] action);
    cfg_write(REG_CODE_FIRST, first);
    cfg_write(REG_CODE_SECOND, second);
    cfg_write(REG_ENTRY_TIMEOUT, timeout);
    cfg_write(REG_ACTION_TICKS, action);
    @(negedge clk);
  endtask

  // item request driver
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      gap_left   <= 0;
    end else begin
      if (item_fire) begin
        predicted_outputs.push_back(lock_step(item));
        taps_sent++;
      end
      // a stalled request holds its payload
      if (!item_valid || item_fire) begin
        if (gap_left != 0) begin
          item_valid <= 1'b0;
          gap_left   <= gap_left - 1;
        end else if (pending_taps.size() != 0) begin
          item       <= pending_taps.pop_front();
          item_valid <= 1'b1;
          gap_left   <= sender_quiet ? 0 : gap_len();
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted on its own
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (result_valid && !result_stall) check_result(result);
      if (hold_left != 0) begin
        result_stall <= 1'b1;
      end else if (stall_left != 0) begin
        result_stall <= 1'b1;
        stall_left   <= stall_left - 1;
      end else if (!receiver_quiet && $urandom_range(0, 3) == 0) begin
        result_stall <= 1'b1;
        stall_left   <= gap_len();
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  task automatic check_result(input result_t got);
    result_t want;
    results_seen++;
    if (predicted_outputs.size() == 0) begin
      $error("result with no request pending: %p", got);
      failures++;
    end else begin
      want = predicted_outputs.pop_front();
      if (got.segments !== want.segments) begin
        $error("segments: expected 0x%02h, actual 0x%02h", want.segments, got.segments);
        failures++;
      end
      if (got.motor_on !== want.motor_on) begin
        $error("motor_on: expected %b, actual %b", want.motor_on, got.motor_on);
        failures++;
      end
      if (got.buzzer_on !== want.buzzer_on) begin
        $error("buzzer_on: expected %b, actual %b", want.buzzer_on, got.buzzer_on);
        failures++;
      end
      if (got.led_on !== want.led_on) begin
        $error("led_on: expected %b, actual %b", want.led_on, got.led_on);
        failures++;
      end
    end
  endtask

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               predicted_outputs.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // test sequence
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed ticks at reset settings, then random entries against the reset code
    foreach (DIRECTED_TAPS[i]) pending_taps.push_back(item_t'(DIRECTED_TAPS[i]));
    drain();
    run_phase(90);
    drain();

    // saturated code, shortest action, no idling on either side
    set_lock(8'd15, 8'd15, 8'd3, 8'd1);
    sender_quiet   = 1'b1;
    receiver_quiet = 1'b1;
    run_phase(60);
    drain();
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;

    // zero code and zero times
    set_lock(8'd0, 8'd0, 8'd0, 8'd0);
    run_phase(30);
    drain();

    // longest entry timeout, one full entry
    set_lock(8'd9, 8'd10, 8'd255, 8'd60);
    queue_entry(0);
    drain();

    // short times with a long receiver hold-off
    set_lock(DATA_W'($urandom_range(0, 3)), DATA_W'($urandom_range(0, 3)), 8'd4, 8'd3);
    hold_req = 1'b1;
    run_phase(100);
    drain();

    // random settings, upper data bits random on the code registers
    set_lock(DATA_W'($urandom_range(0, 255)), DATA_W'($urandom_range(0, 255)),
             DATA_W'($urandom_range(1, 12)), DATA_W'($urandom_range(1, 12)));
    run_phase(40);
    drain();

    if (predicted_outputs.size() != 0) begin
      $error("%0d expected results never arrived", predicted_outputs.size());
      failures++;
    end
    $display("run covered %0d ticks and %0d results over six lock settings",
             taps_sent, results_seen);
    $display("code checks: %0d opened, %0d refused; %0d clears", opens, refusals, clears);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
